// ===== design/emap_pkg.sv =====
// Shared types and constants for the 3x3 edge map block.
`default_nettype none

package emap_pkg;

    localparam int LINE_DEPTH = 2048;                  // pixels per line store
    localparam int COL_W      = $clog2(LINE_DEPTH);    // column index width
    localparam int DIM_W      = 12;                    // width/height register width
    localparam int ROW_W      = DIM_W + 1;             // row count reaches height + 1
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [DIM_W-1:0] MIN_DIM   = DIM_W'(3);
    localparam logic [DIM_W-1:0] MAX_WIDTH = DIM_W'(LINE_DEPTH);
    localparam logic [ROW_W-1:0] MAX_ROWS  = ROW_W'(4096);

    localparam logic MODE_SOBEL     = 1'b0;
    localparam logic MODE_LAPLACIAN = 1'b1;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_SOBEL_TH  = 3'd1;
    localparam logic [2:0] REG_LAP_TH    = 3'd2;
    localparam logic [2:0] REG_WIDTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;

    typedef logic [7:0] pix_t;
    typedef pix_t [8:0] win_t;      // row-major, [0..2] top row

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } tag_t;

    typedef struct packed {
        logic edge_res;
        pix_t strength;
        logic row_end;
        logic frame_end;
    } result_t;

endpackage

`default_nettype wire

// ===== design/emap_line_ram.sv =====
// Line store RAM: upper and middle line packed per column, registered read.
`default_nettype none

module emap_line_ram
    import emap_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [COL_W-1:0] rd_addr,
    output logic      [15:0]      rd_data,
    input  wire logic             wr_en,
    input  wire logic [COL_W-1:0] wr_addr,
    input  wire logic [15:0]      wr_data
);

    logic [15:0] mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/emap_kernel.sv =====
// Sobel / Laplacian kernel: sums in one stage, magnitude, clip and threshold in the next.
`default_nettype none

module emap_kernel
    import emap_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire win_t        in_win,
    input  wire tag_t        in_tag,
    input  wire logic        mode,
    input  wire pix_t        sobel_th,
    input  wire pix_t        lap_th,
    output logic             out_valid,
    output result_t          out_res,
    output logic [1:0]       pending
);

    logic               s1_valid_reg;
    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    logic signed [11:0] lap_reg;
    tag_t               s1_tag_reg;

    logic [9:0]         sum_r;
    logic [9:0]         sum_l;
    logic [9:0]         sum_t;
    logic [9:0]         sum_b;
    logic [10:0]        nbr_sum;
    logic [10:0]        ctr8;
    logic signed [11:0] lap_next;

    logic [9:0]         abs_gx;
    logic [9:0]         abs_gy;
    logic [10:0]        sob_mag;
    logic [10:0]        lap_mag;
    logic [10:0]        mag;
    pix_t               clip;
    logic               flag;
    result_t            res_next;

    always_comb
    begin
        sum_r = 10'(in_win[2]) + {1'b0, in_win[5], 1'b0} + 10'(in_win[8]);
        sum_l = 10'(in_win[0]) + {1'b0, in_win[3], 1'b0} + 10'(in_win[6]);
        sum_t = 10'(in_win[0]) + {1'b0, in_win[1], 1'b0} + 10'(in_win[2]);
        sum_b = 10'(in_win[6]) + {1'b0, in_win[7], 1'b0} + 10'(in_win[8]);
        nbr_sum = 11'(in_win[0]) + 11'(in_win[1]) + 11'(in_win[2]) + 11'(in_win[3])
                + 11'(in_win[5]) + 11'(in_win[6]) + 11'(in_win[7]) + 11'(in_win[8]);
        ctr8 = {in_win[4], 3'b000};
        lap_next = $signed({1'b0, nbr_sum}) - $signed({1'b0, ctr8});
    end

    always_comb
    begin
        abs_gx  = gx_reg[10] ? 10'(-gx_reg) : gx_reg[9:0];
        abs_gy  = gy_reg[10] ? 10'(-gy_reg) : gy_reg[9:0];
        sob_mag = 11'(abs_gx) + 11'(abs_gy);
        lap_mag = lap_reg[11] ? 11'(-lap_reg) : lap_reg[10:0];
        mag     = (mode == MODE_LAPLACIAN) ? lap_mag : sob_mag;
        clip    = (mag > 11'd255) ? 8'hFF : mag[7:0];
        if (mode == MODE_LAPLACIAN)
        begin
            flag = (clip != 8'd0) && (clip >= lap_th);
        end
        else
        begin
            flag = clip > sobel_th;
        end
        res_next.edge_res  = flag;
        res_next.strength  = clip;
        res_next.row_end   = s1_tag_reg.row_end;
        res_next.frame_end = s1_tag_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            out_valid    <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        gx_reg     <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        gy_reg     <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
        lap_reg    <= lap_next;
        s1_tag_reg <= in_tag;
        out_res    <= res_next;
    end

    assign pending = {1'b0, s1_valid_reg} + {1'b0, out_valid};

endmodule

`default_nettype wire

// ===== design/edge_map_3x3_sobel_laplacian.sv =====
// Top level of the 3x3 Sobel / Laplacian edge map over a raster pixel stream.
//
//  channel   dir  handshake                fields
//  s_*       in   s_tvalid / s_tready      s_tuser = kind, s_tdata = pixel
//  m_*       out  m_tvalid / m_tready      m_tdata = edge_res, strength; m_tuser = row_end;
//                                          m_tlast = frame_end
//  APB       in   psel & penable & pwrite  mode, sobel_th, lap_th, width, height
//
//  One item per clock while s_tready is high. A result follows the item that causes it
//  through line store read, window update with kernel sums, magnitude stage, queue write.
//  s_tready drops only when the queue plus the items in flight would overflow it.
//  Reset clears counters, window and queue; the line stores have no clearing pass.
`default_nettype none

module edge_map_3x3_sobel_laplacian
    import emap_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // pixel stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel
    input  wire logic        s_tuser,   // [0] kind
    // result stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [0] edge_res, [8:1] strength, [15:9] zero
    output logic             m_tuser,   // [0] row_end
    output logic             m_tlast    // frame_end
);

    // configuration registers
    logic             mode_reg;
    pix_t             sobel_th_reg;
    pix_t             lap_th_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SOBEL;
            sobel_th_reg <= 8'd180;
            lap_th_reg   <= 8'd50;
            width_reg    <= 12'd640;
            height_reg   <= 12'd480;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MODE:     mode_reg     <= pwdata[0];
                REG_SOBEL_TH: sobel_th_reg <= pwdata[7:0];
                REG_LAP_TH:   lap_th_reg   <= pwdata[7:0];
                REG_WIDTH:    width_reg    <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   height_reg   <= pwdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MODE:     prdata = {31'd0, mode_reg};
            REG_SOBEL_TH: prdata = {24'd0, sobel_th_reg};
            REG_LAP_TH:   prdata = {24'd0, lap_th_reg};
            REG_WIDTH:    prdata = {20'd0, width_reg};
            REG_HEIGHT:   prdata = {20'd0, height_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- stage A: position tracking ----------------
    logic             accept;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [ROW_W-1:0] h_ext;
    logic [ROW_W-1:0] h_p1;
    logic             a_c0;
    logic             a_top_ok;
    logic             a_mid_ok;
    pix_t             a_bot;
    logic             a_emit;
    logic             a_fend;
    logic             a_finish;

    always_comb
    begin
        w_eff = (width_reg < MIN_DIM) ? MIN_DIM :
                ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h_eff = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        h_ext = {1'b0, h_eff};
        h_p1  = h_ext + ROW_W'(1);

        a_c0     = (col_reg == '0);
        a_top_ok = (row_reg >= ROW_W'(2)) && (row_reg < h_p1 + ROW_W'(1));
        a_mid_ok = (row_reg >= ROW_W'(1)) && (row_reg < h_p1);
        a_bot    = (!s_tuser && (row_reg < h_ext)) ? s_tdata : 8'd0;
        if (a_c0)
        begin
            a_emit = (row_reg >= ROW_W'(2)) && (row_reg <= h_p1);
        end
        else
        begin
            a_emit = (row_reg >= ROW_W'(1)) && (row_reg <= h_ext);
        end
        a_fend   = a_c0 && (row_reg == h_p1);
        a_finish = a_c0 && (row_reg >= h_p1);

        if (a_finish)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (({1'b0, col_reg} + DIM_W'(1)) >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage B: line store read-modify-write, window ----------------
    logic             b_valid_reg;
    logic [COL_W-1:0] b_addr_reg;
    pix_t             b_bot_reg;
    logic             b_top_ok_reg;
    logic             b_mid_ok_reg;
    logic             b_c0_reg;
    logic             b_emit_reg;
    logic             b_fend_reg;
    logic             b_finish_reg;
    logic             fwd_hit_reg;
    logic [15:0]      fwd_data_reg;
    win_t             win_reg;

    logic [15:0]      ram_q;
    logic [15:0]      line_q;
    logic [15:0]      wr_data;
    pix_t             b_top;
    pix_t             b_mid;
    win_t             cw;
    win_t             win_next;
    tag_t             b_tag;

    emap_line_ram u_line_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_q),
        .wr_en   (b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (wr_data)
    );

    always_comb
    begin
        // when the item ahead is still in stage B, its write lands in the same cycle as this item's read
        line_q  = fwd_hit_reg ? fwd_data_reg : ram_q;
        b_top   = b_top_ok_reg ? line_q[15:8] : 8'd0;
        b_mid   = b_mid_ok_reg ? line_q[7:0] : 8'd0;
        wr_data = {line_q[7:0], b_bot_reg};

        cw[0] = win_reg[1];
        cw[1] = win_reg[2];
        cw[3] = win_reg[4];
        cw[4] = win_reg[5];
        cw[6] = win_reg[7];
        cw[7] = win_reg[8];
        cw[2] = b_c0_reg ? 8'd0 : b_top;
        cw[5] = b_c0_reg ? 8'd0 : b_mid;
        cw[8] = b_c0_reg ? 8'd0 : b_bot_reg;

        win_next = '0;
        if (!b_finish_reg)
        begin
            if (b_c0_reg)
            begin
                win_next[2] = b_top;
                win_next[5] = b_mid;
                win_next[8] = b_bot_reg;
            end
            else
            begin
                win_next = cw;
            end
        end

        b_tag.row_end   = b_c0_reg;
        b_tag.frame_end = b_fend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= accept;
            fwd_hit_reg <= accept && b_valid_reg && (b_addr_reg == col_reg);
            if (b_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
        if (accept)
        begin
            b_addr_reg   <= col_reg;
            b_bot_reg    <= a_bot;
            b_top_ok_reg <= a_top_ok;
            b_mid_ok_reg <= a_mid_ok;
            b_c0_reg     <= a_c0;
            b_emit_reg   <= a_emit;
            b_fend_reg   <= a_fend;
            b_finish_reg <= a_finish;
        end
    end

    // ---------------- kernel ----------------
    logic       k_valid;
    result_t    k_res;
    logic [1:0] k_pending;

    emap_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg && b_emit_reg),
        .in_win    (cw),
        .in_tag    (b_tag),
        .mode      (mode_reg),
        .sobel_th  (sobel_th_reg),
        .lap_th    (lap_th_reg),
        .out_valid (k_valid),
        .out_res   (k_res),
        .pending   (k_pending)
    );

    // ---------------- output queue ----------------
    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg;
    logic [FIFO_AW:0]   fifo_cnt_next;
    logic [FIFO_AW:0]   committed;
    logic               pop;
    result_t            head;

    assign pop       = m_tvalid && m_tready;
    assign committed = fifo_cnt_reg + (FIFO_AW+1)'(b_valid_reg) + (FIFO_AW+1)'(k_pending);
    // room is reserved for everything already in flight, so stages never stall
    assign s_tready  = committed < (FIFO_AW+1)'(FIFO_DEPTH);
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (k_valid && !pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + (FIFO_AW+1)'(1);
        end
        else if (!k_valid && pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (k_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (k_valid)
        begin
            fifo_mem[wr_ptr_reg] <= k_res;
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {7'd0, head.strength, head.edge_res};
    assign m_tuser  = head.row_end;
    assign m_tlast  = head.frame_end;

`ifndef SYNTHESIS
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        committed <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue over-committed");

    a_frame_end_row_end : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end without row end");

    a_finish_clears : assert property (@(posedge clk) disable iff (!rst_n)
        accept && a_finish |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters not cleared at frame end");

    a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= MAX_ROWS)
        else $error("row count out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_edge_map_3x3_sobel_laplacian.sv =====
// Self-checking testbench for the 3x3 Sobel / Laplacian edge map block.
`timescale 1ns / 100ps

module tb_edge_map_3x3_sobel_laplacian;
    import emap_pkg::*;

    localparam int  HALF_PERIOD  = 4;
    localparam int  RESET_CYCLES = 11;
    localparam int  DRAIN_CYCLES = 20;     // pipeline plus output queue, with margin
    localparam int  STALL_LIMIT  = 2000;   // cycles without any transaction
    localparam int  HOLD_LEN     = 80;
    localparam int  RANDOM_ITEMS = 560;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SNK_STALLS, FLOW_BOTH} flow_t;

    typedef struct packed {
        logic kind;
        pix_t pixel;
    } px_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] pixel
    logic        s_tuser = 1'b0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] edge_res, [8:1] strength
    logic        m_tuser;           // [0] row_end
    logic        m_tlast;           // frame_end

    // shadow of the register file
    logic             cfg_mode = MODE_SOBEL;
    logic [7:0]       cfg_sobel_th = 8'd180;
    logic [7:0]       cfg_lap_th = 8'd50;
    logic [DIM_W-1:0] cfg_width = DIM_W'(640);
    logic [DIM_W-1:0] cfg_height = DIM_W'(480);

    // predictor state
    pix_t upper_store [LINE_DEPTH];
    pix_t middle_store [LINE_DEPTH];
    pix_t win_q [9] = '{default: '0};
    int   col_pos = 0;
    int   row_pos = 0;

    px_item_t pending_px_q [$];
    result_t  edge_exp_q [$];
    flow_t    flow = FLOW_FREE;
    logic     long_hold_go = 1'b0;
    logic     hold_done;
    int       hold_cnt;
    int       error_count = 0;
    int       quiet_cycles = 0;

    edge_map_3x3_sobel_laplacian uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // One pixel transaction through the window; queues the result it produces, if any.
    function automatic void predict_edge(input logic kind, input pix_t px);
        int   w, h, c, r, gx, gy, s;
        int   wi [9];
        pix_t top, mid, bot;
        pix_t cw [9];
        logic emit, rend, fend, finish, flag;
        result_t res;
        w = int'(cfg_width);
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = (int'(cfg_height) < 3) ? 3 : int'(cfg_height);
        c = (col_pos >= LINE_DEPTH) ? 0 : col_pos;
        r = row_pos;
        emit = 1'b0;
        rend = 1'b0;
        fend = 1'b0;
        finish = 1'b0;

        top = (r >= 2 && r - 2 < h) ? upper_store[c] : '0;
        mid = (r >= 1 && r - 1 < h) ? middle_store[c] : '0;
        bot = (kind == KIND_PIXEL && r < h) ? px : '0;
        upper_store[c] = middle_store[c];
        middle_store[c] = bot;

        for (int k = 0; k < 3; k++)
        begin
            cw[k*3]     = win_q[k*3 + 1];
            cw[k*3 + 1] = win_q[k*3 + 2];
        end
        if (c == 0)
        begin
            // column 0 closes the previous row with a zero right edge
            cw[2] = '0;
            cw[5] = '0;
            cw[8] = '0;
            if (r >= 2 && r <= h + 1)
            begin
                emit = 1'b1;
                rend = 1'b1;
                fend = (r == h + 1);
            end
            if (r >= h + 1)
                finish = 1'b1;
        end
        else
        begin
            cw[2] = top;
            cw[5] = mid;
            cw[8] = bot;
            if (r >= 1 && r <= h)
                emit = 1'b1;
        end

        if (emit)
        begin
            for (int k = 0; k < 9; k++)
                wi[k] = int'(cw[k]);
            if (cfg_mode == MODE_SOBEL)
            begin
                gx = (wi[2] + 2*wi[5] + wi[8]) - (wi[0] + 2*wi[3] + wi[6]);
                gy = (wi[0] + 2*wi[1] + wi[2]) - (wi[6] + 2*wi[7] + wi[8]);
                if (gx < 0) gx = -gx;
                if (gy < 0) gy = -gy;
                s = gx + gy;
            end
            else
            begin
                s = -8 * wi[4];
                for (int k = 0; k < 9; k++)
                    if (k != 4)
                        s += wi[k];
                if (s < 0) s = -s;
            end
            if (s > 255) s = 255;
            if (cfg_mode == MODE_SOBEL)
                flag = (s > int'(cfg_sobel_th));
            else
                flag = (s != 0 && s >= int'(cfg_lap_th));
            res.edge_res  = flag;
            res.strength  = pix_t'(s);
            res.row_end   = rend;
            res.frame_end = fend;
            edge_exp_q.push_back(res);
        end

        if (finish)
        begin
            win_q = '{default: '0};
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            if (c == 0)
            begin
                win_q = '{default: '0};
                win_q[2] = top;
                win_q[5] = mid;
                win_q[8] = bot;
            end
            else
                win_q = cw;
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (r + 1) & 32'hFFFF;
            end
            else
                col_pos = c + 1;
        end
    endfunction

    function automatic logic src_gap();
        return (flow == FLOW_SRC_GAPS && $urandom_range(0, 99) < 79) ||
               (flow == FLOW_BOTH && $urandom_range(0, 99) < 32);
    endfunction

    function automatic logic snk_stall();
        return (flow == FLOW_SNK_STALLS && $urandom_range(0, 99) < 79) ||
               (flow == FLOW_BOTH && $urandom_range(0, 99) < 32);
    endfunction

    // pixel source
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        logic holding;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            holding = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_edge(s_tuser, s_tdata);
                void'(pending_px_q.pop_front());
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (pending_px_q.size() != 0 && !src_gap())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_px_q[0].pixel;
                    s_tuser  <= pending_px_q[0].kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result sink and checker
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        logic    ready_next;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (edge_exp_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, tdata %h tuser %b tlast %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = edge_exp_q.pop_front();
                    if (m_tdata[0] !== want.edge_res)
                    begin
                        $display("%0t: edge_res expected %0d got %0d",
                                 $time, want.edge_res, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[8:1] !== want.strength)
                    begin
                        $display("%0t: strength expected %0d got %0d",
                                 $time, want.strength, m_tdata[8:1]);
                        error_count++;
                    end
                    if (m_tuser !== want.row_end)
                    begin
                        $display("%0t: row_end expected %0d got %0d",
                                 $time, want.row_end, m_tuser);
                        error_count++;
                    end
                    if (m_tlast !== want.frame_end)
                    begin
                        $display("%0t: frame_end expected %0d got %0d",
                                 $time, want.frame_end, m_tlast);
                        error_count++;
                    end
                end
            end
            ready_next = !snk_stall();
            // one long back-pressure episode so the input side has to stall
            if (long_hold_go && !hold_done)
            begin
                ready_next = 1'b0;
                if (hold_cnt == HOLD_LEN - 1)
                    hold_done <= 1'b1;
                hold_cnt <= hold_cnt + 1;
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb_edge_map_3x3_sobel_laplacian NOT OK");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:     cfg_mode     = value[0];
            REG_SOBEL_TH: cfg_sobel_th = value[7:0];
            REG_LAP_TH:   cfg_lap_th   = value[7:0];
            REG_WIDTH:    cfg_width    = value[DIM_W-1:0];
            REG_HEIGHT:   cfg_height   = value[DIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_frame_config(input logic mode, input int sob_th, input int lap_th,
                                    input int width, input int height);
        apb_write(REG_MODE, 32'(mode));
        apb_write(REG_SOBEL_TH, 32'(sob_th));
        apb_write(REG_LAP_TH, 32'(lap_th));
        apb_write(REG_WIDTH, 32'(width));
        apb_write(REG_HEIGHT, 32'(height));
    endtask

    // sender pauses until every expected result is out and the pipeline has emptied
    task automatic wait_idle();
        while (pending_px_q.size() != 0 || edge_exp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_item(input logic kind, input pix_t px);
        px_item_t it;
        it.kind  = kind;
        it.pixel = px;
        pending_px_q.push_back(it);
    endtask

    function automatic pix_t pick_pixel();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1:       return pix_t'(120 + $urandom_range(0, 3));   // nearly flat area
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // W*H image items then W+1 drain items, with a little kind noise in both parts
    task automatic push_frame(input int w, input int h);
        for (int i = 0; i < w * h; i++)
            push_item(($urandom_range(0, 19) == 0) ? KIND_FLUSH : KIND_PIXEL, pick_pixel());
        for (int i = 0; i <= w; i++)
            push_item(($urandom_range(0, 9) == 0) ? KIND_PIXEL : KIND_FLUSH,
                      pix_t'($urandom_range(0, 255)));
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial
    begin : stimulus
        int frame_idx;
        int w, h, random_items;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sobel with threshold 0: clipping, a flush inside the image, a pixel in the drain
        set_frame_config(MODE_SOBEL, 0, 255, 3, 3);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_PIXEL, 8'h00);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_PIXEL, 8'h00);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_PIXEL, 8'h00);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_FLUSH, 8'hA5);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_FLUSH, 8'h00);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_FLUSH, 8'h5A);
        push_item(KIND_FLUSH, 8'h00);
        wait_idle();

        // Laplacian, threshold 0, width and height below range (saturate to 3);
        // the bottom-right pixel sees an all-zero window
        set_frame_config(MODE_LAPLACIAN, 255, 0, 2, 0);
        for (int i = 0; i < 3; i++)
            push_item(KIND_PIXEL, 8'hFF);
        for (int i = 0; i < 6; i++)
            push_item(KIND_PIXEL, 8'h00);
        for (int i = 0; i < 4; i++)
            push_item(KIND_FLUSH, 8'h00);
        flow = FLOW_SRC_GAPS;
        wait_idle();

        // height cut below the current row mid-frame: the frame ends with no result
        set_frame_config(MODE_SOBEL, 255, 128, 3, 8);
        for (int i = 0; i < 15; i++)
            push_item(KIND_PIXEL, pick_pixel());
        wait_idle();
        apb_write(REG_HEIGHT, 32'd3);
        push_item(KIND_PIXEL, pick_pixel());
        flow = FLOW_FREE;
        wait_idle();

        frame_idx = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 10);
            h = $urandom_range(3, 6);
            flow = flow_t'(frame_idx % 4);
            set_frame_config(1'($urandom_range(0, 1)), pick_threshold(), pick_threshold(),
                             w, h);
            if (frame_idx == 4)
            begin
                w = 12;
                h = 8;
                apb_write(REG_WIDTH, 32'(w));
                apb_write(REG_HEIGHT, 32'(h));
                long_hold_go = 1'b1;
            end
            push_frame(w, h);
            random_items += w * h + w + 1;
            frame_idx++;
            wait_idle();
        end

        if (error_count == 0 && edge_exp_q.size() == 0)
            $display("tb_edge_map_3x3_sobel_laplacian OK");
        else
            $display("tb_edge_map_3x3_sobel_laplacian NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
design/emap_pkg.sv
design/emap_line_ram.sv
design/emap_kernel.sv
design/edge_map_3x3_sobel_laplacian.sv
tb/tb_edge_map_3x3_sobel_laplacian.sv
